### rtl/mbt_pkg.sv
// Shared types and operation codes for the multiset bag table.
// Used by the controller, the datapath and the top level.
package mbt_pkg;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_COUNT  = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    localparam int unsigned FIELD9_MAX = 511;

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [31:0] key;
    } in_item_t;

    typedef struct packed {
        logic       success;
        logic [8:0] occurrences;
        logic [8:0] total_size;
        logic       is_empty;
    } out_item_t;

    typedef struct packed {
        logic load;
        logic start;
        logic find;
        logic count;
        logic kshift;
        logic spass;
        logic commit;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic       done;
        logic       found;
        logic       occ_one;
        logic       out_free;
        logic [1:0] op;
    } status_t;

endpackage

### rtl/mbt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mbt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### rtl/mbt_ctrl.sv
// Sequencing state machine for the multiset bag table.
// Depends on mbt_pkg; drives mbt_dpath through cmd_t and reads status_t.
module mbt_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic [1:0]      in_op,
    input  mbt_pkg::status_t st,
    output mbt_pkg::cmd_t   cmd
);
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_FIND   = 3'd1;
    localparam logic [2:0] S_COUNT  = 3'd2;
    localparam logic [2:0] S_KSHIFT = 3'd3;
    localparam logic [2:0] S_SPASS  = 3'd4;
    localparam logic [2:0] S_COMMIT = 3'd5;
    localparam logic [2:0] S_EMIT   = 3'd6;

    logic [2:0] state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = (in_op == mbt_pkg::OP_CLEAR) ? S_COMMIT : S_FIND;
                end
            end
            S_FIND: begin
                cmd.find = 1'b1;
                if (st.done) begin
                    cmd.start  = 1'b1;
                    state_next = st.found ? S_COUNT : S_COMMIT;
                end
            end
            S_COUNT: begin
                cmd.count = 1'b1;
                if (st.done) begin
                    cmd.start = 1'b1;
                    if (st.op == mbt_pkg::OP_REMOVE) begin
                        state_next = st.occ_one ? S_KSHIFT : S_SPASS;
                    end else begin
                        state_next = S_COMMIT;
                    end
                end
            end
            S_KSHIFT: begin
                cmd.kshift = 1'b1;
                if (st.done) begin
                    cmd.start  = 1'b1;
                    state_next = S_SPASS;
                end
            end
            S_SPASS: begin
                cmd.spass = 1'b1;
                if (st.done) begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT: begin
                cmd.commit = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT: begin
                if (st.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule

### rtl/mbt_dpath.sv
// Datapath: key and slot stores, scan counter, counts and output register.
// Depends on mbt_pkg and mbt_ram; commanded by mbt_ctrl.
module mbt_dpath #(
    parameter int DISTINCT_DEPTH = 64,
    parameter int SLOT_DEPTH     = 256
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  mbt_pkg::in_item_t  s_data,
    input  mbt_pkg::cmd_t      cmd,
    output mbt_pkg::status_t   st,
    output logic               m_valid,
    input  logic               m_ready,
    output mbt_pkg::out_item_t m_data
);
    localparam int KW  = $clog2(DISTINCT_DEPTH);
    localparam int DCW = $clog2(DISTINCT_DEPTH + 1);
    localparam int SW  = $clog2(SLOT_DEPTH);
    localparam int SCW = $clog2(SLOT_DEPTH + 1);
    localparam int CW  = (SCW > DCW) ? SCW : DCW;

    logic [1:0]         op_reg;
    logic signed [31:0] key_reg;
    logic [DCW-1:0]     dcount_reg, dcount_next;
    logic [SCW-1:0]     scount_reg, scount_next;
    logic [CW-1:0]      ctr_reg, ctr_next;
    logic               rd_vld_reg, rd_vld_next;
    logic [CW-1:0]      rd_idx_reg, rd_idx_next;
    logic               found_reg, found_next;
    logic [KW-1:0]      idx_reg, idx_next;
    logic [SCW-1:0]     occ_reg, occ_next;
    logic [SW-1:0]      last_reg, last_next;
    logic               ok_reg, ok_next;
    logic               m_valid_reg;
    mbt_pkg::out_item_t m_data_reg;

    logic          key_we, slot_we;
    logic [KW-1:0] key_waddr, key_raddr;
    logic [31:0]   key_wdata, key_rdata;
    logic [SW-1:0] slot_waddr, slot_raddr;
    logic [KW-1:0] slot_wdata, slot_rdata, slot_adj;

    logic [CW:0]   r_idx;
    logic          read_go;
    logic          occ_one;
    logic          d_room, s_room;
    logic [31:0]   occ_w, sc_w;

    mbt_ram #(.WIDTH(32), .DEPTH(DISTINCT_DEPTH)) u_keys (
        .aclk(aclk), .we(key_we), .waddr(key_waddr), .wdata(key_wdata),
        .raddr(key_raddr), .rdata(key_rdata)
    );

    mbt_ram #(.WIDTH(KW), .DEPTH(SLOT_DEPTH)) u_slots (
        .aclk(aclk), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
        .raddr(slot_raddr), .rdata(slot_rdata)
    );

    assign occ_one = (occ_reg == SCW'(1));
    assign d_room  = ({1'b0, dcount_reg} < (DCW+1)'(DISTINCT_DEPTH));
    assign s_room  = ({1'b0, scount_reg} < (SCW+1)'(SLOT_DEPTH));

    always_comb begin
        if (cmd.kshift) begin
            r_idx   = (CW+1)'(idx_reg) + (CW+1)'(1) + (CW+1)'(ctr_reg);
            read_go = r_idx < (CW+1)'(dcount_reg);
        end else if (cmd.find) begin
            r_idx   = (CW+1)'(ctr_reg);
            read_go = r_idx < (CW+1)'(dcount_reg);
        end else begin
            r_idx   = (CW+1)'(ctr_reg);
            read_go = (cmd.count || cmd.spass) && (r_idx < (CW+1)'(scount_reg));
        end
    end

    assign key_raddr  = r_idx[KW-1:0];
    assign slot_raddr = r_idx[SW-1:0];
    assign slot_adj   = (occ_one && (slot_rdata > idx_reg)) ? slot_rdata - KW'(1) : slot_rdata;

    always_comb begin
        key_we     = 1'b0;
        key_waddr  = rd_idx_reg[KW-1:0] - KW'(1);
        key_wdata  = key_rdata;
        slot_we    = 1'b0;
        slot_waddr = rd_idx_reg[SW-1:0];
        slot_wdata = slot_adj;
        if (cmd.kshift && rd_vld_reg) begin
            key_we = 1'b1;
        end
        if (cmd.spass && rd_vld_reg) begin
            if (rd_idx_reg[SW-1:0] < last_reg) begin
                slot_we = 1'b1;
            end else if (rd_idx_reg[SW-1:0] > last_reg) begin
                slot_we    = 1'b1;
                slot_waddr = rd_idx_reg[SW-1:0] - SW'(1);
            end
        end
        if (cmd.commit && op_reg == mbt_pkg::OP_ADD) begin
            slot_waddr = scount_reg[SW-1:0];
            if (found_reg) begin
                slot_we    = s_room;
                slot_wdata = idx_reg;
            end else begin
                slot_we    = s_room && d_room;
                slot_wdata = dcount_reg[KW-1:0];
                key_we     = s_room && d_room;
                key_waddr  = dcount_reg[KW-1:0];
                key_wdata  = key_reg;
            end
        end
    end

    always_comb begin
        dcount_next = dcount_reg;
        scount_next = scount_reg;
        ctr_next    = ctr_reg;
        rd_vld_next = 1'b0;
        rd_idx_next = r_idx[CW-1:0];
        found_next  = found_reg;
        idx_next    = idx_reg;
        occ_next    = occ_reg;
        last_next   = last_reg;
        ok_next     = ok_reg;
        if (cmd.load || cmd.start) begin
            ctr_next = '0;
        end else if (read_go) begin
            ctr_next    = ctr_reg + CW'(1);
            rd_vld_next = 1'b1;
        end
        if (cmd.load) begin
            found_next = 1'b0;
            occ_next   = '0;
        end
        if (cmd.find && rd_vld_reg && !found_reg && key_rdata == key_reg) begin
            found_next = 1'b1;
            idx_next   = rd_idx_reg[KW-1:0];
        end
        if (cmd.count && rd_vld_reg && slot_rdata == idx_reg) begin
            occ_next  = occ_reg + SCW'(1);
            last_next = rd_idx_reg[SW-1:0];
        end
        if (cmd.commit) begin
            unique case (op_reg)
                mbt_pkg::OP_ADD: begin
                    if (found_reg) begin
                        ok_next = s_room;
                        if (s_room) begin
                            occ_next    = occ_reg + SCW'(1);
                            scount_next = scount_reg + SCW'(1);
                        end
                    end else begin
                        ok_next  = s_room && d_room;
                        occ_next = SCW'(s_room && d_room);
                        if (s_room && d_room) begin
                            scount_next = scount_reg + SCW'(1);
                            dcount_next = dcount_reg + DCW'(1);
                        end
                    end
                end
                mbt_pkg::OP_REMOVE: begin
                    ok_next = found_reg;
                    if (found_reg) begin
                        occ_next    = occ_reg - SCW'(1);
                        scount_next = scount_reg - SCW'(1);
                        if (occ_one) begin
                            dcount_next = dcount_reg - DCW'(1);
                        end
                    end
                end
                mbt_pkg::OP_COUNT: begin
                    ok_next = (occ_reg != '0);
                end
                mbt_pkg::OP_CLEAR: begin
                    ok_next     = 1'b1;
                    occ_next    = '0;
                    scount_next = '0;
                    dcount_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dcount_reg  <= '0;
            scount_reg  <= '0;
            ctr_reg     <= '0;
            rd_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            dcount_reg <= dcount_next;
            scount_reg <= scount_next;
            ctr_reg    <= ctr_next;
            rd_vld_reg <= rd_vld_next;
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign occ_w = 32'(occ_reg);
    assign sc_w  = 32'(scount_reg);

    always_ff @(posedge aclk) begin
        rd_idx_reg <= rd_idx_next;
        found_reg  <= found_next;
        idx_reg    <= idx_next;
        occ_reg    <= occ_next;
        last_reg   <= last_next;
        ok_reg     <= ok_next;
        if (cmd.load) begin
            op_reg  <= s_data.operation;
            key_reg <= s_data.key;
        end
        if (cmd.emit) begin
            m_data_reg.success     <= ok_reg;
            m_data_reg.occurrences <= (occ_w > mbt_pkg::FIELD9_MAX) ? 9'd511 : occ_w[8:0];
            m_data_reg.total_size  <= (sc_w > mbt_pkg::FIELD9_MAX) ? 9'd511 : sc_w[8:0];
            m_data_reg.is_empty    <= (scount_reg == '0);
        end
    end

    assign st.done     = !read_go && !rd_vld_reg;
    assign st.found    = found_reg;
    assign st.occ_one  = occ_one;
    assign st.out_free = !m_valid_reg || m_ready;
    assign st.op       = op_reg;
    assign m_valid     = m_valid_reg;
    assign m_data      = m_data_reg;
endmodule

### rtl/multiset_bag_table_core.sv
// Multiset bag table top level: controller plus datapath.
// Scans read one RAM entry a cycle: add, count and remove scan the keys, then the slots
// for a known key; remove of a known key then rewrites the slots to close the gap, after
// shifting the keys down when its last occurrence goes; clear skips the scans.
// One item at a time: the next transfer is taken once the result loads, even while it waits.
// Synchronous active-low reset empties the bag.
module multiset_bag_table_core #(
    parameter int DISTINCT_DEPTH = 64,
    parameter int SLOT_DEPTH     = 256
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  mbt_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output mbt_pkg::out_item_t m_data
);
    mbt_pkg::cmd_t    cmd;
    mbt_pkg::status_t st;

    mbt_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .in_op(s_data.operation), .st(st), .cmd(cmd)
    );

    mbt_dpath #(.DISTINCT_DEPTH(DISTINCT_DEPTH), .SLOT_DEPTH(SLOT_DEPTH)) u_dpath (
        .aclk(aclk), .aresetn(aresetn), .s_data(s_data), .cmd(cmd), .st(st),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );
endmodule
